FILE: rtl/gfsk_pkg.sv
// ----------------------------------------------------------------------------
// gfsk_pkg: shared constants, tables and functions for the GFSK generator
// Pulse-shaping and quarter-wave cosine tables are built at elaboration.
// ----------------------------------------------------------------------------
package gfsk_pkg;

  localparam int NUM_SYMBOLS      = 79;
  localparam int PHASE_BITS       = 32;
  localparam int PULSE_TABLE_BITS = 8;
  localparam int COS_TABLE_BITS   = 10;

  localparam int SI_W   = $clog2(NUM_SYMBOLS);
  localparam int CNT_W  = $clog2(NUM_SYMBOLS + 1);
  localparam int QN     = 2 ** (COS_TABLE_BITS - 2);
  localparam int HN     = 2 ** PULSE_TABLE_BITS + 1;
  localparam int HIDX_W = PULSE_TABLE_BITS + 1;
  localparam int SUM_W  = 20;
  localparam int PROD_W = 32 + SUM_W;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;

  localparam logic [63:0] ONE30    = 64'd1 << 30;
  localparam longint      ONE30S   = 64'sd1073741824;
  localparam logic [63:0] HALFPI   = 64'd1686629713;
  localparam logic [63:0] SLOPE    = 64'd11458972746;
  localparam logic [63:0] XMAX     = 64'd4831838208;
  localparam logic [63:0] AS_P     = 64'd351748265;
  localparam longint      AS_A1    = 64'sd273621191;
  localparam longint      AS_A2    = -64'sd305476044;
  localparam longint      AS_A3    = 64'sd1526231383;
  localparam longint      AS_A4    = -64'sd1560310108;
  localparam longint      AS_A5    = 64'sd1139675401;

  typedef logic [15:0] qtab_t [QN];
  typedef logic [15:0] htab_t [HN];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], n[k]};
      if (rem >= d) begin
        rem  = rem - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] poly_c(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = ONE30 - x2 / 56;
    t  = ONE30 - ((x2 * t) >> 30) / 30;
    t  = ONE30 - ((x2 * t) >> 30) / 12;
    t  = ONE30 - ((x2 * t) >> 30) / 2;
    return t;
  endfunction

  function automatic logic [63:0] poly_s(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = ONE30 - x2 / 72;
    t  = ONE30 - ((x2 * t) >> 30) / 42;
    t  = ONE30 - ((x2 * t) >> 30) / 20;
    t  = ONE30 - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [63:0] quarter_val(input logic [63:0] r, input logic want_sin);
    logic [63:0] x;
    if (r <= (ONE30 >> 1)) begin
      x = (r * HALFPI) >> 30;
      return want_sin ? poly_s(x) : poly_c(x);
    end
    x = ((ONE30 - r) * HALFPI) >> 30;
    return want_sin ? poly_c(x) : poly_s(x);
  endfunction

  function automatic qtab_t gen_qtab(input logic want_sin);
    qtab_t       tab;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] m;
    for (int k = 0; k < QN; k++) begin
      r      = 64'(k) << (32 - COS_TABLE_BITS);
      v      = quarter_val(r, want_sin);
      m      = (v * 64'd32767 + (ONE30 >> 1)) >> 30;
      tab[k] = m[15:0];
    end
    return tab;
  endfunction

  function automatic logic [63:0] exp_neg(input logic [63:0] y);
    logic [63:0] v;
    logic [63:0] t;
    v = y >> 5;
    t = ONE30 - v / 7;
    t = ONE30 - ((v * t) >> 30) / 6;
    t = ONE30 - ((v * t) >> 30) / 5;
    t = ONE30 - ((v * t) >> 30) / 4;
    t = ONE30 - ((v * t) >> 30) / 3;
    t = ONE30 - ((v * t) >> 30) / 2;
    t = ONE30 - ((v * t) >> 30);
    for (int k = 0; k < 5; k++) t = (t * t) >> 30;
    return t;
  endfunction

  function automatic logic [15:0] half_erfc(input logic [63:0] i);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] den;
    logic [63:0] e;
    logic [63:0] ec;
    logic [63:0] h;
    longint      t;
    longint      p;
    x = (SLOPE * i) >> PULSE_TABLE_BITS;
    if (x >= XMAX) return 16'd0;
    y   = ((x >> 6) * (x >> 6)) >> 18;
    den = ONE30 + ((AS_P * x) >> 30);
    t   = longint'(udiv64(ONE30 << 30, den));
    p   = AS_A5;
    p   = AS_A4 + p * t / ONE30S;
    p   = AS_A3 + p * t / ONE30S;
    p   = AS_A2 + p * t / ONE30S;
    p   = AS_A1 + p * t / ONE30S;
    p   = p * t / ONE30S;
    if (p < 0) p = 0;
    e  = exp_neg(y);
    ec = (64'(p) * e) >> 30;
    h  = (ec + (64'd1 << 14)) >> 15;
    if (h > 64'd32768) h = 64'd32768;
    return h[15:0];
  endfunction

  function automatic htab_t gen_htab();
    htab_t tab;
    for (int k = 0; k < HN; k++) tab[k] = half_erfc(64'(k));
    return tab;
  endfunction

  localparam qtab_t QC_TAB = gen_qtab(1'b0);
  localparam qtab_t QS_TAB = gen_qtab(1'b1);
  localparam htab_t H_TAB  = gen_htab();

  function automatic logic signed [15:0] cos_lut(input logic [COS_TABLE_BITS-1:0] q);
    logic [COS_TABLE_BITS-3:0] k;
    logic signed [15:0]        v;
    k = q[COS_TABLE_BITS-3:0];
    unique case (q[COS_TABLE_BITS-1 -: 2])
      2'd0:    v = signed'(QC_TAB[k]);
      2'd1:    v = -signed'(QS_TAB[k]);
      2'd2:    v = -signed'(QC_TAB[k]);
      default: v = signed'(QS_TAB[k]);
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/gfsk_store.sv
// ----------------------------------------------------------------------------
// gfsk_store: tone symbol memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gfsk_store import gfsk_pkg::*; (
  input  logic            clk,
  input  logic            we,
  input  logic [SI_W-1:0] waddr,
  input  logic [2:0]      wdata,
  input  logic [SI_W-1:0] raddr,
  output logic [2:0]      rdata_r
);

  logic [2:0] mem [NUM_SYMBOLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/gfsk_nco_waveform_generator_top.sv
// ----------------------------------------------------------------------------
// gfsk_nco_waveform_generator_top: GFSK tone burst generator
// Symbol store plus symbol and carrier NCOs with Gaussian tone blending.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one command per transfer:
//   load a tone into the symbol store, restart the burst, or produce a
//   sample. Load and restart give no result. A sample command steps
//   through states S_PREV, S_CURR, S_NEXT, S_MUL and S_DONE: three
//   reads of the symbol memory read port (previous, current, next tone),
//   the tone-weight multiply, then phase update and output. The
//   sequencer handles one command at a time.
//   Output channel (out_valid/out_stall) carries sample and finished.
//   The output register holds a result while the receiver stalls; the
//   next sample is computed meanwhile and waits in its last step until
//   the register frees.
//   Reset clears both phases, the symbol count, both step registers and
//   the output valid. The symbol store is not cleared; load every entry
//   before a burst.
//   Configuration: carrier_step at 0x0, symbol_step at 0x4, written
//   while idle.
// ----------------------------------------------------------------------------
module gfsk_nco_waveform_generator_top import gfsk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [6:0]         in_symbol_index,
  input  logic [2:0]         in_symbol_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_finished,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {S_IDLE, S_PREV, S_CURR, S_NEXT, S_MUL, S_DONE} state_t;

  localparam logic [PHASE_BITS-1:0] RAMP_LO = PHASE_BITS'(1) << (PHASE_BITS - 3);
  localparam logic [PHASE_BITS-1:0] RAMP_HI = PHASE_BITS'(7) << (PHASE_BITS - 3);

  state_t                 state_r;
  logic [31:0]            cs_r, ss_r;
  logic [PHASE_BITS-1:0]  cp_r, sp_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [15:0]            wp_r, wn_r;
  logic [2:0]             tp_r, tc_r;
  logic [SUM_W-1:0]       sum_r;
  logic [PROD_W-1:0]      prod_r;
  logic signed [15:0]     c_r, rc_r;
  logic [15:0]            amp_r;
  logic [29:0]            mag_r;
  logic                   neg_r;
  logic                   out_valid_r;
  logic signed [15:0]     out_sample_r;
  logic                   out_finished_r;

  logic                   in_xfer, fin, we;
  logic [SI_W-1:0]        raddr;
  logic [CNT_W-1:0]       raddr_w;
  logic [2:0]             rdata_r;
  logic [PULSE_TABLE_BITS-1:0] pi;
  logic [HIDX_W-1:0]      wn_idx;
  logic [16:0]            wc;
  logic [2:0]             tn;
  logic [SUM_W-1:0]       sum_nxt;
  logic                   ramp;
  logic [16:0]            ramp_amp;
  logic signed [31:0]     ac;
  logic [31:0]            ac_abs;
  logic [30:0]            qsum;
  logic [15:0]            q0, q;
  logic [30:0]            rem;
  logic [PROD_W:0]        incw;
  logic [PHASE_BITS-1:0]  inc, nsp;
  logic                   hold_out;

  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fin = (cnt_r >= CNT_W'(NUM_SYMBOLS));
  assign we = in_xfer && (in_command == CMD_LOAD) &&
              (32'(in_symbol_index) < NUM_SYMBOLS);
  assign pi = sp_r[PHASE_BITS-1 -: PULSE_TABLE_BITS];
  assign wn_idx = HIDX_W'(2 ** PULSE_TABLE_BITS) - {1'b0, pi};

  always_comb begin
    case (state_r)
      S_IDLE:  raddr_w = cnt_r - CNT_W'(1);
      S_PREV:  raddr_w = cnt_r;
      default: raddr_w = cnt_r + CNT_W'(1);
    endcase
  end
  assign raddr = raddr_w[SI_W-1:0];

  gfsk_store u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (in_symbol_index[SI_W-1:0]),
    .wdata   (in_symbol_value),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

  assign tn = fin ? 3'd0 : ((cnt_r == CNT_W'(NUM_SYMBOLS - 1)) ? tc_r : rdata_r);
  assign wc = 17'd65536 - 17'(wp_r) - 17'(wn_r);
  assign sum_nxt = SUM_W'(tp_r) * SUM_W'(wp_r) + SUM_W'(tc_r) * SUM_W'(wc) +
                   SUM_W'(tn) * SUM_W'(wn_r);
  assign ramp = ((cnt_r == '0) && (sp_r <= RAMP_LO)) ||
                ((cnt_r == CNT_W'(NUM_SYMBOLS - 1)) && (sp_r >= RAMP_HI));
  assign ramp_amp = (17'd32767 - 17'(rc_r)) >> 1;

  assign ac = signed'({16'd0, amp_r}) * 32'(c_r);
  assign ac_abs = ac[31] ? -ac : ac;

  assign qsum = 31'(mag_r) + 31'(mag_r >> 15);
  assign q0 = qsum[30:15];
  assign rem = 31'(mag_r) - (({15'd0, q0} << 15) - 31'(q0));
  assign q = (rem >= 31'd32767) ? q0 + 16'd1 : q0;

  assign incw = {1'b0, cs_r, 16'd0} + (PROD_W + 1)'(prod_r);
  assign inc = incw[16 +: PHASE_BITS];
  assign nsp = sp_r + ss_r[PHASE_BITS-1:0];
  assign hold_out = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cs_r        <= '0;
      ss_r        <= '0;
      cp_r        <= '0;
      sp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2]) ss_r <= pwdata;
        else cs_r <= pwdata;
      end
      if (out_valid_r && !out_stall && (state_r != S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_command == CMD_RESTART) begin
              cp_r  <= '0;
              sp_r  <= '0;
              cnt_r <= '0;
            end else if (in_command == CMD_SAMPLE) begin
              wp_r    <= H_TAB[{1'b0, pi}];
              state_r <= S_PREV;
            end
          end
        end
        S_PREV: begin
          tp_r    <= fin ? 3'd0 : ((cnt_r == '0) ? 3'd3 : rdata_r);
          wn_r    <= H_TAB[wn_idx];
          state_r <= S_CURR;
        end
        S_CURR: begin
          tc_r    <= fin ? 3'd0 : rdata_r;
          rc_r    <= cos_lut(sp_r[PHASE_BITS-3 -: COS_TABLE_BITS]);
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          sum_r   <= sum_nxt;
          c_r     <= cos_lut(cp_r[PHASE_BITS-1 -: COS_TABLE_BITS]);
          amp_r   <= ramp ? ramp_amp[15:0] : 16'd32767;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PROD_W'(ss_r) * PROD_W'(sum_r);
          mag_r   <= ac_abs[29:0];
          neg_r   <= ac[31];
          state_r <= S_DONE;
        end
        default: begin
          if (!hold_out) begin
            out_valid_r    <= 1'b1;
            out_sample_r   <= neg_r ? -signed'(q) : signed'(q);
            out_finished_r <= fin;
            if ((nsp < sp_r) && !fin) cnt_r <= cnt_r + CNT_W'(1);
            sp_r    <= nsp;
            cp_r    <= cp_r + inc;
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_finished = out_finished_r;
  assign pready       = 1'b1;
  assign prdata       = paddr[2] ? ss_r : cs_r;

endmodule

FILE: rtl/gfsk_checker.sv
// ----------------------------------------------------------------------------
// gfsk_checker: port-level checks for the GFSK generator
// Bound to the top level.
// ----------------------------------------------------------------------------
module gfsk_checker import gfsk_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_command,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sample
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample))
    else $error("stalled output changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_SAMPLE |=> in_stall)
    else $error("sample command not held busy");

  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !in_stall |=> !out_valid)
    else $error("result repeated after transfer");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample != -16'sd32768)
    else $error("sample out of range");

endmodule

bind gfsk_nco_waveform_generator_top gfsk_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_sample (out_sample)
);
